// File: hw/rtl/rational_radial_distortion_unit_defines.svh
// Assertion macros shared by the rational radial distortion RTL.
`ifndef RATIONAL_RADIAL_DISTORTION_UNIT_DEFINES_SVH
`define RATIONAL_RADIAL_DISTORTION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rrd_pkg.sv
// Package: widths, register codes, shared types and clamp function.
package rrd_pkg;

  localparam int unsigned COEFF_W    = 32;
  localparam int unsigned RADIUS_W   = 16;
  localparam int unsigned FACTOR_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned INT_BITS   = 8;
  localparam int unsigned R2_W       = 2 * RADIUS_W;
  localparam int unsigned P2_W       = R2_W - 4;
  localparam int unsigned P4_W       = 32;
  localparam int unsigned P6_W       = 36;
  localparam int unsigned HI_W       = P6_W - FRAC_BITS;
  localparam int unsigned HI_PROD_W  = COEFF_W + HI_W + 1;
  localparam int unsigned LO_PROD_W  = COEFF_W + FRAC_BITS + 1;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned MAG_W      = 47;
  localparam int unsigned QUO_W      = INT_BITS + FRAC_BITS;
  localparam int unsigned CMP_W      = MAG_W + INT_BITS;
  localparam int unsigned NUM_TERMS  = 6;

  localparam logic signed [SUM_W-1:0] Q_ONE = SUM_W'(1) <<< FRAC_BITS;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = {1'b0, {(FACTOR_W-1){1'b1}}};
  localparam logic [FACTOR_W-1:0] FACTOR_MIN = {1'b1, {(FACTOR_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(1) << (FACTOR_W - 1);
  localparam logic [MAG_W-1:0] POS_LIMIT = NEG_LIMIT - MAG_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_R2 = 3'd0,
    REG_NUM_R4 = 3'd1,
    REG_NUM_R6 = 3'd2,
    REG_DEN_R2 = 3'd3,
    REG_DEN_R4 = 3'd4,
    REG_DEN_R6 = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COEFF_W-1:0] num_r2;
    logic signed [COEFF_W-1:0] num_r4;
    logic signed [COEFF_W-1:0] num_r6;
    logic signed [COEFF_W-1:0] den_r2;
    logic signed [COEFF_W-1:0] den_r4;
    logic signed [COEFF_W-1:0] den_r6;
  } coeff_t;

  // Handoff from the polynomial front end to the divider
  typedef struct packed {
    logic                neg;
    logic [MAG_W-1:0]    n;
    logic [MAG_W-1:0]    d;
    logic                dz;
    logic [FACTOR_W-1:0] dz_factor;
    logic                dz_sat;
  } div_in_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic                denominator_zero;
    logic                saturated;
  } result_t;

  typedef struct packed {
    logic                sat;
    logic [FACTOR_W-1:0] value;
  } clamp_t;

  // Apply sign to a magnitude and clamp to Q8.24
  function automatic clamp_t clamp_mag(input logic neg, input logic [MAG_W-1:0] mag);
    clamp_t c;
    c.sat   = 1'b0;
    c.value = FACTOR_W'(mag);
    if (!neg) begin
      if (mag > POS_LIMIT) begin
        c.sat   = 1'b1;
        c.value = FACTOR_MAX;
      end
    end else begin
      if (mag > NEG_LIMIT) begin
        c.sat   = 1'b1;
        c.value = FACTOR_MIN;
      end else begin
        c.value = -mag[FACTOR_W-1:0];
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/rrd_in_if.sv
// Input channel: one radius item per handshake.
interface rrd_in_if;
  logic                          valid;
  logic                          ready;
  logic [rrd_pkg::RADIUS_W-1:0]  radius;

  modport source (output valid, output radius, input ready);
  modport sink   (input valid, input radius, output ready);
endinterface

// File: hw/rtl/rrd_out_if.sv
// Output channel: factor and status flags per handshake.
interface rrd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rrd_pkg::FACTOR_W-1:0] factor;
  logic                                denominator_zero;
  logic                                saturated;

  modport source (output valid, output factor, output denominator_zero, output saturated,
                  input ready);
  modport sink   (input valid, input factor, input denominator_zero, input saturated,
                  output ready);
endinterface

// File: hw/rtl/rrd_cfg_regs.sv
// Coefficient register file written through the plain config port.
module rrd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rrd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rrd_pkg::COEFF_W-1:0]     cfg_wdata_i,
  output rrd_pkg::coeff_t                 coeff_o
);

  rrd_pkg::coeff_t coeff_d, coeff_q;

  // Decode write; unknown indexes are dropped
  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rrd_pkg::REG_NUM_R2: coeff_d.num_r2 = cfg_wdata_i;
        rrd_pkg::REG_NUM_R4: coeff_d.num_r4 = cfg_wdata_i;
        rrd_pkg::REG_NUM_R6: coeff_d.num_r6 = cfg_wdata_i;
        rrd_pkg::REG_DEN_R2: coeff_d.den_r2 = cfg_wdata_i;
        rrd_pkg::REG_DEN_R4: coeff_d.den_r4 = cfg_wdata_i;
        rrd_pkg::REG_DEN_R6: coeff_d.den_r6 = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  assign coeff_o = coeff_q;

endmodule

// File: hw/rtl/rrd_poly.sv
// Front end: powers of r, coefficient products, numerator/denominator sums.
module rrd_poly (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [rrd_pkg::RADIUS_W-1:0]  radius_i,
  input  rrd_pkg::coeff_t               coeff_i,
  output logic                          valid_o,
  output rrd_pkg::div_in_t              data_o
);

  localparam int unsigned NSTAGE = 7;
  localparam int unsigned R2_W   = rrd_pkg::R2_W;
  localparam int unsigned P6_W   = rrd_pkg::P6_W;
  localparam int unsigned FB     = rrd_pkg::FRAC_BITS;
  localparam int unsigned SUM_W  = rrd_pkg::SUM_W;
  localparam int unsigned NT     = rrd_pkg::NUM_TERMS;

  logic [NSTAGE-1:0] vld_q;

  // stage 1..3: powers
  logic [R2_W-1:0]            r2_1_q, r2_2_q;
  logic [2*R2_W-1:0]          sq4, prod6;
  logic [rrd_pkg::P4_W-1:0]   p4_2_q, p4_3_q;
  logic [rrd_pkg::P2_W-1:0]   p2_3_q;
  logic [P6_W-1:0]            p6_3_q;

  // stage 4..7: products, terms, sums, magnitudes
  logic signed [rrd_pkg::COEFF_W-1:0]    coef   [NT];
  logic [P6_W-1:0]                       pw     [NT];
  logic signed [rrd_pkg::HI_W:0]         hi_op  [NT];
  logic signed [FB:0]                    lo_op  [NT];
  logic signed [rrd_pkg::HI_PROD_W-1:0]  hi_d   [NT];
  logic signed [rrd_pkg::LO_PROD_W-1:0]  lo_d   [NT];
  logic signed [rrd_pkg::HI_PROD_W-1:0]  hi_4_q [NT];
  logic signed [rrd_pkg::LO_PROD_W-1:0]  lo_4_q [NT];
  logic signed [SUM_W-1:0]               term_d [NT];
  logic signed [SUM_W-1:0]               term_5_q [NT];
  logic signed [SUM_W-1:0]               num_6_q, den_6_q;
  logic signed [SUM_W-1:0]               num_abs, den_abs;
  rrd_pkg::div_in_t                      out_d, out_7_q;
  rrd_pkg::clamp_t                       dz_clamp;

  assign sq4   = (2*R2_W)'(r2_1_q) * (2*R2_W)'(r2_1_q);
  assign prod6 = (2*R2_W)'(p4_2_q) * (2*R2_W)'(r2_2_q);

  // operand lists: numerator terms first, then denominator
  assign coef[0] = coeff_i.num_r2;
  assign coef[1] = coeff_i.num_r4;
  assign coef[2] = coeff_i.num_r6;
  assign coef[3] = coeff_i.den_r2;
  assign coef[4] = coeff_i.den_r4;
  assign coef[5] = coeff_i.den_r6;
  assign pw[0]   = P6_W'(p2_3_q);
  assign pw[1]   = P6_W'(p4_3_q);
  assign pw[2]   = p6_3_q;
  assign pw[3]   = P6_W'(p2_3_q);
  assign pw[4]   = P6_W'(p4_3_q);
  assign pw[5]   = p6_3_q;

  // c*p split at bit 24 so each multiplier stays narrow
  always_comb begin
    for (int j = 0; j < NT; j++) begin
      hi_op[j] = $signed({1'b0, pw[j][P6_W-1:FB]});
      lo_op[j] = $signed({1'b0, pw[j][FB-1:0]});
      hi_d[j]  = coef[j] * hi_op[j];
      lo_d[j]  = coef[j] * lo_op[j];
    end
  end

  // floor(c*p / 2^24) = hi + floor(lo / 2^24)
  always_comb begin
    for (int j = 0; j < NT; j++) begin
      term_d[j] = SUM_W'(hi_4_q[j]) + SUM_W'(lo_4_q[j] >>> FB);
    end
  end

  // sign/magnitude split and zero-denominator result
  always_comb begin
    num_abs        = num_6_q[SUM_W-1] ? -num_6_q : num_6_q;
    den_abs        = den_6_q[SUM_W-1] ? -den_6_q : den_6_q;
    out_d.neg      = num_6_q[SUM_W-1] ^ den_6_q[SUM_W-1];
    out_d.n        = num_abs[rrd_pkg::MAG_W-1:0];
    out_d.d        = den_abs[rrd_pkg::MAG_W-1:0];
    out_d.dz       = (den_6_q == '0);
    dz_clamp       = rrd_pkg::clamp_mag(num_6_q[SUM_W-1], num_abs[rrd_pkg::MAG_W-1:0]);
    out_d.dz_factor = dz_clamp.value;
    out_d.dz_sat   = dz_clamp.sat;
  end

  // valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NSTAGE-2:0], valid_i};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r2_1_q  <= R2_W'(radius_i) * R2_W'(radius_i);
      r2_2_q  <= r2_1_q;
      p4_2_q  <= sq4[2*R2_W-1:R2_W];
      p4_3_q  <= p4_2_q;
      p2_3_q  <= r2_2_q[R2_W-1:4];
      p6_3_q  <= prod6[2*R2_W-1:28];
      for (int j = 0; j < NT; j++) begin
        hi_4_q[j]   <= hi_d[j];
        lo_4_q[j]   <= lo_d[j];
        term_5_q[j] <= term_d[j];
      end
      num_6_q <= rrd_pkg::Q_ONE + term_5_q[0] + term_5_q[1] + term_5_q[2];
      den_6_q <= rrd_pkg::Q_ONE + term_5_q[3] + term_5_q[4] + term_5_q[5];
      out_7_q <= out_d;
    end
  end

  assign valid_o = vld_q[NSTAGE-1];
  assign data_o  = out_7_q;

endmodule

// File: hw/rtl/rrd_div.sv
// Pipelined restoring divider, one quotient bit per stage, plus final clamp.
module rrd_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  rrd_pkg::div_in_t     data_i,
  output logic                 valid_o,
  output rrd_pkg::result_t     res_o
);

  localparam int unsigned QUO_W    = rrd_pkg::QUO_W;
  localparam int unsigned MAG_W    = rrd_pkg::MAG_W;
  localparam int unsigned CMP_W    = rrd_pkg::CMP_W;
  localparam int unsigned INT_BITS = rrd_pkg::INT_BITS;

  typedef struct packed {
    logic                         neg;
    logic                         dz;
    logic                         ovf;
    logic                         dz_sat;
    logic [rrd_pkg::FACTOR_W-1:0] dz_factor;
    logic [MAG_W-1:0]             d;
  } ctl_t;

  logic [QUO_W:0]    vld_q;
  logic              fin_vld_q;
  ctl_t              ctl0_d;
  ctl_t              ctl_q   [QUO_W+1];
  logic [MAG_W-1:0]  rem_q   [QUO_W+1];
  logic [QUO_W-1:0]  quo_q   [QUO_W+1];
  logic [MAG_W-1:0]  rem_d   [QUO_W];
  logic [QUO_W-1:0]  quo_d   [QUO_W];
  rrd_pkg::clamp_t   fin_clamp;
  rrd_pkg::result_t  res_d, res_q;

  // entry: quotient must fit in eight integer bits
  always_comb begin
    ctl0_d.neg       = data_i.neg;
    ctl0_d.dz        = data_i.dz;
    ctl0_d.dz_sat    = data_i.dz_sat;
    ctl0_d.dz_factor = data_i.dz_factor;
    ctl0_d.d         = data_i.d;
    ctl0_d.ovf       = ({{INT_BITS{1'b0}}, data_i.n} >= {data_i.d, {INT_BITS{1'b0}}});
  end

  // integer bits compare against shifted divisor, fraction bits shift the remainder
  always_comb begin
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] div_sh;
    logic [CMP_W-1:0] diff;
    logic             ge;
    for (int k = 0; k < QUO_W; k++) begin
      if (k < INT_BITS) begin
        rem_ext = CMP_W'(rem_q[k]);
        div_sh  = CMP_W'(ctl_q[k].d) << (INT_BITS - 1 - k);
      end else begin
        rem_ext = CMP_W'({rem_q[k], 1'b0});
        div_sh  = CMP_W'(ctl_q[k].d);
      end
      ge       = (rem_ext >= div_sh);
      diff     = rem_ext - div_sh;
      rem_d[k] = ge ? diff[MAG_W-1:0] : rem_ext[MAG_W-1:0];
      quo_d[k] = {quo_q[k][QUO_W-2:0], ge};
    end
  end

  // sign, clamp and special cases
  always_comb begin
    fin_clamp = rrd_pkg::clamp_mag(ctl_q[QUO_W].neg, MAG_W'(quo_q[QUO_W]));
    priority if (ctl_q[QUO_W].dz) begin
      res_d.factor           = ctl_q[QUO_W].dz_factor;
      res_d.denominator_zero = 1'b1;
      res_d.saturated        = ctl_q[QUO_W].dz_sat;
    end else if (ctl_q[QUO_W].ovf) begin
      res_d.factor           = ctl_q[QUO_W].neg ? rrd_pkg::FACTOR_MIN : rrd_pkg::FACTOR_MAX;
      res_d.denominator_zero = 1'b0;
      res_d.saturated        = 1'b1;
    end else begin
      res_d.factor           = fin_clamp.value;
      res_d.denominator_zero = 1'b0;
      res_d.saturated        = fin_clamp.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fin_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q     <= {vld_q[QUO_W-1:0], valid_i};
      fin_vld_q <= vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q[0] <= ctl0_d;
      rem_q[0] <= data_i.n;
      quo_q[0] <= '0;
      for (int k = 0; k < QUO_W; k++) begin
        ctl_q[k+1] <= ctl_q[k];
        rem_q[k+1] <= rem_d[k];
        quo_q[k+1] <= quo_d[k];
      end
      res_q <= res_d;
    end
  end

  assign valid_o = fin_vld_q;
  assign res_o   = res_q;

endmodule

// File: hw/rtl/rrd_outbuf.sv
// Output register with one skid entry; sets the pipeline advance.
`include "rational_radial_distortion_unit_defines.svh"

module rrd_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rrd_pkg::result_t  data_i,
  output logic              adv_o,
  rrd_out_if.source         out_if
);

  logic              out_valid_d, out_valid_q;
  logic              skid_full_d, skid_full_q;
  rrd_pkg::result_t  out_data_d, out_data_q;
  rrd_pkg::result_t  skid_data_d, skid_data_q;
  logic              out_fire;

  // pipeline moves while the skid entry is free
  assign adv_o    = !skid_full_q;
  assign out_fire = out_valid_q && out_if.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    out_data_d  = out_data_q;
    skid_data_d = skid_data_q;
    if (skid_full_q) begin
      if (out_fire) begin
        out_data_d  = skid_data_q;
        skid_full_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_d = valid_i;
      out_data_d  = data_i;
    end else if (valid_i) begin
      skid_full_d = 1'b1;
      skid_data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.factor           = out_data_q.factor;
  assign out_if.denominator_zero = out_data_q.denominator_zero;
  assign out_if.saturated        = out_data_q.saturated;

  // skid only holds an item behind a pending output
  `RRD_ASSERT_IMP(a_skid_behind_out, skid_full_q, out_valid_q, "skid full without output item")
  // an item arriving at a blocked output lands in the skid
  `RRD_ASSERT_NEXT(a_no_drop, valid_i && !skid_full_q && out_valid_q && !out_if.ready,
                   skid_full_q, "item from pipeline dropped at blocked output")
  // a taken output drains the skid into the output register
  `RRD_ASSERT_NEXT(a_skid_drain, skid_full_q && out_if.ready, !skid_full_q && out_valid_q,
                   "skid entry not moved to output")

endmodule

// File: hw/rtl/rational_radial_distortion_unit.sv
// Throughput: one item per cycle while the skid entry is free; 7 front-end stages,
// 34 divider stages (one quotient bit per stage, 32 bits) and an output register
// with one skid entry.
// Output backpressure freezes the whole pipeline once the skid entry is taken.
// Reset clears valid bits, the output buffer's valid and skid flags and all six coefficients to zero.
module rational_radial_distortion_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rrd_pkg::COEFF_W-1:0]    cfg_wdata_i,
  rrd_in_if.sink                         in_if,
  rrd_out_if.source                      out_if
);

  logic              adv;
  rrd_pkg::coeff_t   coeff;
  logic              poly_valid;
  rrd_pkg::div_in_t  poly_data;
  logic              div_valid;
  rrd_pkg::result_t  div_res;

  assign in_if.ready = adv;

  rrd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coeff_o     (coeff)
  );

  rrd_poly u_poly (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_if.valid),
    .radius_i (in_if.radius),
    .coeff_i  (coeff),
    .valid_o  (poly_valid),
    .data_o   (poly_data)
  );

  rrd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (poly_valid),
    .data_i  (poly_data),
    .valid_o (div_valid),
    .res_o   (div_res)
  );

  rrd_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .data_i  (div_res),
    .adv_o   (adv),
    .out_if  (out_if)
  );

endmodule
